// ===== design/dtlfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// dtlfifo_pkg
// Shared types, sizes and codes of the two-level deduplicating ID FIFO.
// ----------------------------------------------------------------------------
package dtlfifo_pkg;

	localparam int RING_SLOTS = 8;
	localparam int WAIT_SLOTS = 32;
	localparam int ID_BITS    = 16;

	// Field widths fixed by the interface.
	localparam int ID_W   = 16;
	localparam int CAP_W  = 4;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 4;

	localparam int RING_AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int RING_CW = $clog2(RING_SLOTS + 1);
	localparam int RING_SW = RING_CW + 1;
	localparam int WAIT_AW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
	localparam int WAIT_CW = $clog2(WAIT_SLOTS + 1);
	localparam int WAIT_SW = WAIT_CW + 1;

	localparam logic [ID_W-1:0]  ID_MASK   = ID_W'((64'd1 << ID_BITS) - 64'd1);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

	typedef enum logic [REQ_W-1:0] {
		REQ_ARRIVE   = 2'd0,
		REQ_COMPLETE = 2'd1,
		REQ_PEEK     = 2'd2,
		REQ_PEEK_ALT = 2'd3
	} req_type_e;

	typedef enum logic [STAT_W-1:0] {
		ST_TO_RING      = 4'd0,
		ST_TO_WAIT      = 4'd1,
		ST_DUPLICATE    = 4'd2,
		ST_WAIT_FULL    = 4'd3,
		ST_DONE_NONE    = 4'd4,
		ST_DONE_PROMOTE = 4'd5,
		ST_RING_EMPTY   = 4'd6,
		ST_PEEK_OK      = 4'd7,
		ST_WAIT_EMPTY   = 4'd8
	} status_e;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0]  item_id;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   done_id;
		logic [ID_W-1:0]   moved_id;
	} rsp_t;

	// Capacity register clamped to the built ring size; zero acts as one.
	function automatic logic [RING_CW-1:0] usable_slots(input logic [CAP_W-1:0] cap);
		int c;
		c = int'(cap);
		if (c < 1) c = 1;
		if (c > RING_SLOTS) c = RING_SLOTS;
		return RING_CW'(c);
	endfunction

endpackage

// ===== design/dtlfifo_ram.sv =====
// ----------------------------------------------------------------------------
// dtlfifo_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dtlfifo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/dedup_two_level_fifo_top.sv =====
// ----------------------------------------------------------------------------
// dedup_two_level_fifo_top
// Ring of service slots backed by an overflow FIFO, with a duplicate check.
// ----------------------------------------------------------------------------
// Complete and peek read both heads on acceptance and finish directly; the
// result strobe follows in the cycle after the finishing state. Arrive scans
// both memories in parallel, one entry of each per cycle, then finishes; its
// strobe is likewise registered from the finishing state.
// One request is in work at a time and the result beat cannot be stalled.
// Reset clears head pointers and counts and sets the capacity to 8; memories keep contents.
module dedup_two_level_fifo_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  dtlfifo_pkg::req_t          req,
	output logic                       rsp_valid,
	output dtlfifo_pkg::rsp_t          rsp,
	input  logic                       cfg_wr_en,
	input  logic [dtlfifo_pkg::CAP_W-1:0] cfg_wr_data
);

	dtlfifo_pkg::fsm_state_t state_q, state_d;

	logic [dtlfifo_pkg::CAP_W-1:0]   cap_q;
	dtlfifo_pkg::req_t               req_q;
	logic [dtlfifo_pkg::RING_AW-1:0] ring_head_q, ring_head_d;
	logic [dtlfifo_pkg::RING_CW-1:0] ring_count_q, ring_count_d;
	logic [dtlfifo_pkg::WAIT_AW-1:0] wait_head_q, wait_head_d;
	logic [dtlfifo_pkg::WAIT_CW-1:0] wait_count_q, wait_count_d;

	// Scan pointers and remaining entry counts.
	logic [dtlfifo_pkg::RING_AW-1:0] ring_ptr_q;
	logic [dtlfifo_pkg::RING_CW-1:0] ring_left_q;
	logic [dtlfifo_pkg::WAIT_AW-1:0] wait_ptr_q;
	logic [dtlfifo_pkg::WAIT_CW-1:0] wait_left_q;
	logic                            ring_cmp_s1, wait_cmp_s1;
	logic                            hit_q;

	logic                            rsp_valid_q;
	dtlfifo_pkg::rsp_t               rsp_q, rsp_d;

	logic                            accept;
	logic [dtlfifo_pkg::ID_W-1:0]    id_in;
	logic [dtlfifo_pkg::ID_W-1:0]    id_q;
	logic [dtlfifo_pkg::RING_AW-1:0] ring_ptr_inc, ring_head_inc, ring_tail;
	logic [dtlfifo_pkg::WAIT_AW-1:0] wait_ptr_inc, wait_head_inc, wait_tail;
	logic [dtlfifo_pkg::RING_SW-1:0] ring_sum;
	logic [dtlfifo_pkg::WAIT_SW-1:0] wait_sum;
	logic [dtlfifo_pkg::RING_CW-1:0] usable;

	logic                            ring_re, ring_we;
	logic [dtlfifo_pkg::RING_AW-1:0] ring_raddr;
	logic [dtlfifo_pkg::ID_W-1:0]    ring_wdata, ring_rdata;
	logic                            wait_re, wait_we;
	logic [dtlfifo_pkg::WAIT_AW-1:0] wait_raddr;
	logic [dtlfifo_pkg::ID_W-1:0]    wait_rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != dtlfifo_pkg::FSM_IDLE);
	assign id_in  = req.item_id & dtlfifo_pkg::ID_MASK;
	assign id_q   = req_q.item_id & dtlfifo_pkg::ID_MASK;
	assign usable = dtlfifo_pkg::usable_slots(cap_q);

	assign ring_ptr_inc  = (ring_ptr_q == dtlfifo_pkg::RING_AW'(dtlfifo_pkg::RING_SLOTS - 1))
		? '0 : ring_ptr_q + 1'b1;
	assign ring_head_inc = (ring_head_q == dtlfifo_pkg::RING_AW'(dtlfifo_pkg::RING_SLOTS - 1))
		? '0 : ring_head_q + 1'b1;
	assign wait_ptr_inc  = (wait_ptr_q == dtlfifo_pkg::WAIT_AW'(dtlfifo_pkg::WAIT_SLOTS - 1))
		? '0 : wait_ptr_q + 1'b1;
	assign wait_head_inc = (wait_head_q == dtlfifo_pkg::WAIT_AW'(dtlfifo_pkg::WAIT_SLOTS - 1))
		? '0 : wait_head_q + 1'b1;

	// Tail is head plus count, wrapped once; the head is below the slot count, the count at most equal to it.
	assign ring_sum  = dtlfifo_pkg::RING_SW'(ring_head_q) + dtlfifo_pkg::RING_SW'(ring_count_q);
	assign ring_tail = (ring_sum >= dtlfifo_pkg::RING_SW'(dtlfifo_pkg::RING_SLOTS))
		? dtlfifo_pkg::RING_AW'(ring_sum - dtlfifo_pkg::RING_SW'(dtlfifo_pkg::RING_SLOTS))
		: dtlfifo_pkg::RING_AW'(ring_sum);
	assign wait_sum  = dtlfifo_pkg::WAIT_SW'(wait_head_q) + dtlfifo_pkg::WAIT_SW'(wait_count_q);
	assign wait_tail = (wait_sum >= dtlfifo_pkg::WAIT_SW'(dtlfifo_pkg::WAIT_SLOTS))
		? dtlfifo_pkg::WAIT_AW'(wait_sum - dtlfifo_pkg::WAIT_SW'(dtlfifo_pkg::WAIT_SLOTS))
		: dtlfifo_pkg::WAIT_AW'(wait_sum);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtlfifo_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = (req.req_type == dtlfifo_pkg::REQ_ARRIVE)
						? dtlfifo_pkg::FSM_SCAN : dtlfifo_pkg::FSM_FINISH;
				end
			end
			dtlfifo_pkg::FSM_SCAN: begin
				if (ring_left_q == '0 && wait_left_q == '0 && !ring_cmp_s1 && !wait_cmp_s1) begin
					state_d = dtlfifo_pkg::FSM_FINISH;
				end
			end
			dtlfifo_pkg::FSM_FINISH: begin
				state_d = dtlfifo_pkg::FSM_IDLE;
			end
			default: begin
				state_d = dtlfifo_pkg::FSM_IDLE;
			end
		endcase
	end

	// Memory accesses, pointer updates and the result.
	always_comb begin
		ring_re      = 1'b0;
		ring_raddr   = ring_ptr_q;
		wait_re      = 1'b0;
		wait_raddr   = wait_ptr_q;
		ring_we      = 1'b0;
		ring_wdata   = id_q;
		wait_we      = 1'b0;
		ring_head_d  = ring_head_q;
		ring_count_d = ring_count_q;
		wait_head_d  = wait_head_q;
		wait_count_d = wait_count_q;
		rsp_d        = '0;
		unique case (state_q)
			dtlfifo_pkg::FSM_IDLE: begin
				// Complete and peek read both heads right away.
				if (accept && req.req_type != dtlfifo_pkg::REQ_ARRIVE) begin
					ring_re    = 1'b1;
					ring_raddr = ring_head_q;
					wait_re    = 1'b1;
					wait_raddr = wait_head_q;
				end
			end
			dtlfifo_pkg::FSM_SCAN: begin
				ring_re = (ring_left_q != '0);
				wait_re = (wait_left_q != '0);
			end
			dtlfifo_pkg::FSM_FINISH: begin
				unique case (req_q.req_type)
					dtlfifo_pkg::REQ_ARRIVE: begin
						if (hit_q) begin
							rsp_d.status = dtlfifo_pkg::ST_DUPLICATE;
						end else if (ring_count_q < usable) begin
							ring_we      = 1'b1;
							ring_count_d = ring_count_q + 1'b1;
							rsp_d.status = dtlfifo_pkg::ST_TO_RING;
						end else if (wait_count_q < dtlfifo_pkg::WAIT_CW'(dtlfifo_pkg::WAIT_SLOTS)) begin
							wait_we      = 1'b1;
							wait_count_d = wait_count_q + 1'b1;
							rsp_d.status = dtlfifo_pkg::ST_TO_WAIT;
						end else begin
							rsp_d.status = dtlfifo_pkg::ST_WAIT_FULL;
						end
					end
					dtlfifo_pkg::REQ_COMPLETE: begin
						if (ring_count_q == '0) begin
							rsp_d.status = dtlfifo_pkg::ST_RING_EMPTY;
						end else begin
							rsp_d.done_id = ring_rdata;
							ring_head_d   = ring_head_inc;
							if (wait_count_q == '0) begin
								ring_count_d = ring_count_q - 1'b1;
								rsp_d.status = dtlfifo_pkg::ST_DONE_NONE;
							end else begin
								// Pop and push cancel: the promoted ID lands at the old
								// tail, which is head plus count before the pop.
								ring_we        = 1'b1;
								ring_wdata     = wait_rdata;
								wait_head_d    = wait_head_inc;
								wait_count_d   = wait_count_q - 1'b1;
								rsp_d.moved_id = wait_rdata;
								rsp_d.status   = dtlfifo_pkg::ST_DONE_PROMOTE;
							end
						end
					end
					dtlfifo_pkg::REQ_PEEK, dtlfifo_pkg::REQ_PEEK_ALT: begin
						if (wait_count_q == '0) begin
							rsp_d.status = dtlfifo_pkg::ST_WAIT_EMPTY;
						end else begin
							rsp_d.moved_id = wait_rdata;
							rsp_d.status   = dtlfifo_pkg::ST_PEEK_OK;
						end
					end
					default: begin
						rsp_d.status = dtlfifo_pkg::ST_WAIT_EMPTY;
					end
				endcase
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dtlfifo_pkg::FSM_IDLE;
			cap_q        <= dtlfifo_pkg::CAP_RESET;
			ring_head_q  <= '0;
			ring_count_q <= '0;
			wait_head_q  <= '0;
			wait_count_q <= '0;
			ring_left_q  <= '0;
			wait_left_q  <= '0;
			ring_cmp_s1  <= 1'b0;
			wait_cmp_s1  <= 1'b0;
			hit_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			ring_head_q  <= ring_head_d;
			ring_count_q <= ring_count_d;
			wait_head_q  <= wait_head_d;
			wait_count_q <= wait_count_d;
			rsp_valid_q  <= (state_q == dtlfifo_pkg::FSM_FINISH);
			ring_cmp_s1  <= (state_q == dtlfifo_pkg::FSM_SCAN) && ring_re;
			wait_cmp_s1  <= (state_q == dtlfifo_pkg::FSM_SCAN) && wait_re;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (accept) begin
				ring_left_q <= ring_count_q;
				wait_left_q <= wait_count_q;
				hit_q       <= 1'b0;
			end else if (state_q == dtlfifo_pkg::FSM_SCAN) begin
				if (ring_re) begin
					ring_left_q <= ring_left_q - 1'b1;
				end
				if (wait_re) begin
					wait_left_q <= wait_left_q - 1'b1;
				end
				if ((ring_cmp_s1 && ring_rdata == id_q) || (wait_cmp_s1 && wait_rdata == id_q)) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= '{req_type: req.req_type, item_id: id_in};
			ring_ptr_q <= ring_head_q;
			wait_ptr_q <= wait_head_q;
		end else if (state_q == dtlfifo_pkg::FSM_SCAN) begin
			if (ring_re) begin
				ring_ptr_q <= ring_ptr_inc;
			end
			if (wait_re) begin
				wait_ptr_q <= wait_ptr_inc;
			end
		end
		if (state_q == dtlfifo_pkg::FSM_FINISH) begin
			rsp_q <= rsp_d;
		end
	end

	dtlfifo_ram #(
		.WIDTH(dtlfifo_pkg::ID_W),
		.DEPTH(dtlfifo_pkg::RING_SLOTS)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_tail),
		.wdata(ring_wdata),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	dtlfifo_ram #(
		.WIDTH(dtlfifo_pkg::ID_W),
		.DEPTH(dtlfifo_pkg::WAIT_SLOTS)
	) u_wait_ram (
		.clk  (clk),
		.we   (wait_we),
		.waddr(wait_tail),
		.wdata(id_q),
		.re   (wait_re),
		.raddr(wait_raddr),
		.rdata(wait_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A result beat always comes out after the block has gone idle.
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !busy)
		else $error("result beat while busy");

	// Every result beat directly follows a finishing cycle.
	a_rsp_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(state_q == dtlfifo_pkg::FSM_FINISH))
		else $error("result beat without a finishing cycle");

	// Occupancy never exceeds the built sizes.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_count_q <= dtlfifo_pkg::RING_CW'(dtlfifo_pkg::RING_SLOTS)) &&
		(wait_count_q <= dtlfifo_pkg::WAIT_CW'(dtlfifo_pkg::WAIT_SLOTS)))
		else $error("queue count beyond its size");

	// Memory writes happen only while finishing a request.
	a_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_we || wait_we) |-> (state_q == dtlfifo_pkg::FSM_FINISH))
		else $error("memory write outside the finishing cycle");

endmodule
